@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define C3RB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("c3rb assertion failed");
`define C3RB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c3rb assertion failed");
`else
`define C3RB_ASSERT(label, clk, rst_n, prop)
`define C3RB_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/c3rb_pkg.sv @@
`default_nettype none
package c3rb_pkg;

  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int DimW       = 11;
  localparam int KernW      = 36;
  localparam int PixW       = 8;
  localparam int CoefW      = 4;
  localparam int OutRowW    = 10;
  localparam int OutColW    = 10;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 36;
  localparam int ProdW      = PixW + 1 + CoefW;
  localparam int SumW       = 16;
  localparam int RecipW     = 13;
  localparam int Recip9     = 7282;
  localparam int RecipShift = 16;
  localparam int QProdW     = SumW - 1 + RecipW;
  localparam int QuotW      = QProdW - RecipShift;

  localparam logic [DimW-1:0]  ImageWidthRst   = DimW'(640);
  localparam logic [DimW-1:0]  ImageHeightRst  = DimW'(480);
  localparam logic [KernW-1:0] KernelCoeffsRst = 36'h11010F0FF;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth   = 2'd0,
    CfgImageHeight  = 2'd1,
    CfgKernelCoeffs = 2'd2
  } cfg_idx_e;

  typedef logic [PixW-1:0] pix_t;
  typedef pix_t [8:0] win_t;

  typedef struct packed {
    win_t             pix;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic             last;
  } job_t;

  function automatic logic signed [CoefW-1:0] coeff_at(input logic [KernW-1:0] kern,
                                                        input logic [3:0] idx);
    coeff_at = kern[CoefW*idx +: CoefW];
  endfunction

endpackage
`default_nettype wire

@@ design/c3rb_if.sv @@
`default_nettype none
interface c3rb_pix_if;
  import c3rb_pkg::*;
  logic valid;
  logic ready;
  logic [PixW-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface c3rb_res_if;
  import c3rb_pkg::*;
  logic valid;
  logic ready;
  logic [PixW-1:0]    value;
  logic [OutRowW-1:0] out_row;
  logic [OutColW-1:0] out_col;
  logic               frame_end;
  modport source (output valid, output value, output out_row, output out_col,
                  output frame_end, input ready);
  modport sink (input valid, input value, input out_row, input out_col,
                input frame_end, output ready);
endinterface
`default_nettype wire

@@ design/c3rb_ram.sv @@
`default_nettype none
module c3rb_ram #(
  parameter int Depth = 1024,
  parameter int Width = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

@@ design/c3rb_front.sv @@
`default_nettype none
`include "assert_macros.svh"
module c3rb_front (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [c3rb_pkg::DimW-1:0] image_width_i,
  input  wire logic [c3rb_pkg::DimW-1:0] image_height_i,
  input  wire logic                   in_valid_i,
  input  wire logic [c3rb_pkg::PixW-1:0] in_pixel_i,
  output logic                        in_ready_o,
  output logic                        job_valid_o,
  output c3rb_pkg::job_t              job_o,
  input  wire logic                   job_ready_i
);
  import c3rb_pkg::*;

  localparam logic [1:0] JobMid    = 2'd0;
  localparam logic [1:0] JobBottom = 2'd1;
  localparam logic [1:0] JobRight  = 2'd2;
  localparam logic [1:0] JobCorner = 2'd3;

  logic [ColW:0]   w_eff;
  logic [RowW:0]   h_eff;
  logic [ColW-1:0] col_q, col_d, c_in;
  logic [RowW-1:0] row_q, row_d, r_in;
  logic            last_col, last_row, accept;

  logic            b_valid_q;
  pix_t            b_pix_q;
  logic [ColW-1:0] b_col_q;
  logic [RowW-1:0] b_row_q;
  logic            b_last_row_q, b_last_col_q, b_top_q, b_left_q, b_emit_q;
  logic            b_adv;

  logic [2*PixW-1:0] rdata;
  logic              ram_we, ram_re;
  logic [ColW-1:0]   ram_waddr, ram_raddr;

  win_t            win_q, win_d;
  logic [3:0]      mask_q, mask_d;
  win_t            bw_q;
  logic [RowW-1:0] brow_q;
  logic [ColW-1:0] bcol_q;
  logic            btop_q, bleft_q;
  logic            issue, burst_free;
  logic [1:0]      kind;

  always_comb begin
    if (image_width_i < DimW'(2)) begin
      w_eff = (ColW+1)'(2);
    end else if (int'(image_width_i) > MaxWidth) begin
      w_eff = (ColW+1)'(MaxWidth);
    end else begin
      w_eff = (ColW+1)'(image_width_i);
    end
    if (image_height_i < DimW'(2)) begin
      h_eff = (RowW+1)'(2);
    end else if (int'(image_height_i) > MaxHeight) begin
      h_eff = (RowW+1)'(MaxHeight);
    end else begin
      h_eff = (RowW+1)'(image_height_i);
    end
  end

  always_comb begin
    if ({1'b0, col_q} >= w_eff || {1'b0, row_q} >= h_eff) begin
      c_in = '0;
      r_in = '0;
    end else begin
      c_in = col_q;
      r_in = row_q;
    end
    last_col = ({1'b0, c_in} == w_eff - 1'b1);
    last_row = ({1'b0, r_in} == h_eff - 1'b1);
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : r_in + 1'b1;
    end else begin
      col_d = c_in + 1'b1;
      row_d = r_in;
    end
  end

  assign accept     = in_valid_i && in_ready_o;
  assign b_adv      = b_valid_q && burst_free;
  assign in_ready_o = !b_valid_q || b_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q     <= col_d;
        row_q     <= row_d;
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_pix_q      <= in_pixel_i;
      b_col_q      <= c_in;
      b_row_q      <= r_in;
      b_last_row_q <= last_row;
      b_last_col_q <= last_col;
      b_top_q      <= (r_in == RowW'(1));
      b_left_q     <= (c_in == ColW'(1));
      b_emit_q     <= (r_in != '0) && (c_in != '0);
    end
  end

  // Each entry holds the two previous rows of one column: older in the low byte.
  assign ram_re    = accept;
  assign ram_raddr = c_in;
  assign ram_we    = b_adv;
  assign ram_waddr = b_col_q;

  c3rb_ram #(
    .Depth(MaxWidth),
    .Width(2*PixW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({b_pix_q, rdata[2*PixW-1:PixW]}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_d[i*3]   = win_q[i*3+1];
      win_d[i*3+1] = win_q[i*3+2];
    end
    win_d[2] = rdata[PixW-1:0];
    win_d[5] = rdata[2*PixW-1:PixW];
    win_d[8] = b_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (b_adv) begin
      win_q <= win_d;
    end
  end

  // The burst register issues one pixel's results, one per cycle unless stalled.
  assign job_valid_o = |mask_q;
  assign issue       = job_valid_o && job_ready_i;
  assign mask_d      = issue ? (mask_q & (mask_q - 4'd1)) : mask_q;
  assign burst_free  = (mask_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (b_adv) begin
      mask_q <= b_emit_q ? {b_last_row_q && b_last_col_q, b_last_col_q, b_last_row_q, 1'b1}
                         : 4'd0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      bw_q    <= win_d;
      brow_q  <= b_row_q - 1'b1;
      bcol_q  <= b_col_q - 1'b1;
      btop_q  <= b_top_q;
      bleft_q <= b_left_q;
    end
  end

  always_comb begin
    logic       bot, right;
    logic [1:0] rs [3];
    logic [1:0] cs [3];
    logic [3:0] idx;
    if (mask_q[0]) begin
      kind = JobMid;
    end else if (mask_q[1]) begin
      kind = JobBottom;
    end else if (mask_q[2]) begin
      kind = JobRight;
    end else begin
      kind = JobCorner;
    end
    bot   = (kind == JobBottom) || (kind == JobCorner);
    right = (kind == JobRight) || (kind == JobCorner);
    rs[0] = bot ? 2'd1 : (btop_q ? 2'd1 : 2'd0);
    rs[1] = bot ? 2'd2 : 2'd1;
    rs[2] = 2'd2;
    cs[0] = right ? 2'd1 : (bleft_q ? 2'd1 : 2'd0);
    cs[1] = right ? 2'd2 : 2'd1;
    cs[2] = 2'd2;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        idx = 4'(rs[i] * 3 + cs[j]);
        job_o.pix[i*3+j] = bw_q[idx];
      end
    end
    job_o.row  = brow_q + {{(RowW-1){1'b0}}, bot};
    job_o.col  = bcol_q + {{(ColW-1){1'b0}}, right};
    job_o.last = (kind == JobCorner);
  end

  `C3RB_ASSERT(a_ram_no_collide, clk_i, rst_ni, (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
  `C3RB_ASSERT(a_frame_end_final, clk_i, rst_ni, (job_valid_o && job_o.last) |-> !(|mask_q[2:0]))
  `C3RB_ASSERT_NEXT(a_b_holds, clk_i, rst_ni, (b_valid_q && !b_adv), (b_valid_q && $stable(b_col_q) && $stable(rdata)))
endmodule
`default_nettype wire

@@ design/c3rb_mac.sv @@
`default_nettype none
`include "assert_macros.svh"
module c3rb_mac (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [c3rb_pkg::KernW-1:0] kernel_coeffs_i,
  input  wire logic                       job_valid_i,
  input  wire c3rb_pkg::job_t             job_i,
  output logic                            job_ready_o,
  output logic                            res_valid_o,
  input  wire logic                       res_ready_i,
  output logic [c3rb_pkg::PixW-1:0]       value_o,
  output logic [c3rb_pkg::OutRowW-1:0]    out_row_o,
  output logic [c3rb_pkg::OutColW-1:0]    out_col_o,
  output logic                            frame_end_o
);
  import c3rb_pkg::*;

  logic                   p1_valid_q, p1_free, p1_go;
  job_t                   p1_job_q;
  logic                   p2_valid_q, p2_free, p2_go;
  logic signed [SumW-1:0] p2_sum_q, sum;
  logic [RowW-1:0]        p2_row_q;
  logic [ColW-1:0]        p2_col_q;
  logic                   p2_last_q;
  logic                   o_valid_q, o_free;
  logic [PixW-1:0]        value_q, value_d;
  logic [OutRowW-1:0]     row_q;
  logic [OutColW-1:0]     col_q;
  logic                   last_q;
  logic [QProdW-1:0]      qprod;
  logic [QuotW-1:0]       quot;

  assign o_free      = !o_valid_q || res_ready_i;
  assign p2_go       = p2_valid_q && o_free;
  assign p2_free     = !p2_valid_q || o_free;
  assign p1_go       = p1_valid_q && p2_free;
  assign p1_free     = !p1_valid_q || p2_free;
  assign job_ready_o = p1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      o_valid_q  <= 1'b0;
    end else begin
      if (p1_free) begin
        p1_valid_q <= job_valid_i;
      end
      if (p2_free) begin
        p2_valid_q <= p1_go;
      end
      if (o_free) begin
        o_valid_q <= p2_go;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_free && job_valid_i) begin
      p1_job_q <= job_i;
    end
  end

  always_comb begin
    logic signed [PixW:0]    px_s;
    logic signed [ProdW-1:0] prod;
    sum = '0;
    for (int k = 0; k < 9; k++) begin
      px_s = {1'b0, p1_job_q.pix[k]};
      prod = px_s * coeff_at(kernel_coeffs_i, 4'(k));
      sum  = sum + SumW'(prod);
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_go) begin
      p2_sum_q  <= sum;
      p2_row_q  <= p1_job_q.row;
      p2_col_q  <= p1_job_q.col;
      p2_last_q <= p1_job_q.last;
    end
  end

  // Division by nine uses a rounded-up reciprocal, exact over the sum's range.
  always_comb begin
    qprod = QProdW'(p2_sum_q[SumW-2:0]) * QProdW'(Recip9);
    quot  = qprod[QProdW-1:RecipShift];
    if (p2_sum_q[SumW-1]) begin
      value_d = '0;
    end else if (quot > QuotW'(255)) begin
      value_d = '1;
    end else begin
      value_d = quot[PixW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_go) begin
      value_q <= value_d;
      row_q   <= p2_row_q[OutRowW-1:0];
      col_q   <= p2_col_q[OutColW-1:0];
      last_q  <= p2_last_q;
    end
  end

  assign res_valid_o = o_valid_q;
  assign value_o     = value_q;
  assign out_row_o   = row_q;
  assign out_col_o   = col_q;
  assign frame_end_o = last_q;

  `C3RB_ASSERT_NEXT(a_neg_to_zero, clk_i, rst_ni, (p2_go && p2_sum_q[SumW-1]), (value_q == '0))
endmodule
`default_nettype wire

@@ design/conv3x3_replicate_border_top.sv @@
// 3x3 convolution filter with replicated borders for 8-bit grayscale frames.
// Pixels enter in raster order on pix_in; each request carries one pixel.
// Filtered pixels leave on res_out with their row, column and a flag on the
// last result of the frame. The result for row y, column x is released by
// the request for pixel (y+1, x+1); the right column and the bottom row are
// released together with it, so one request gives zero to four results.
// A result passes the input, burst, p1, p2 and output registers to res_out.
// Requests are taken one per cycle while each releases at most one result and
// res_out does not stall; a request with several results holds the input until
// the single multiply-accumulate pipeline, one result per cycle, takes them all.
// The two previous rows live in one line memory read and written once per pixel.
// Reset clears the position counters and the window and loads the default
// geometry and kernel; the line memory is not cleared and needs no clearing.
// When res_out stalls, the result pipeline fills and pix_in.ready drops.
// Configuration goes through cfg_we_i, cfg_idx_i and cfg_data_i; the user must
// write it while the block is idle (not enforced); unused indices are ignored.
`default_nettype none
module conv3x3_replicate_border_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [c3rb_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [c3rb_pkg::CfgDataW-1:0] cfg_data_i,
  c3rb_pix_if.sink                           pix_in,
  c3rb_res_if.source                         res_out
);
  import c3rb_pkg::*;

  logic [DimW-1:0]  image_width_q;
  logic [DimW-1:0]  image_height_q;
  logic [KernW-1:0] kernel_coeffs_q;
  logic             job_valid, job_ready;
  job_t             job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q   <= ImageWidthRst;
      image_height_q  <= ImageHeightRst;
      kernel_coeffs_q <= KernelCoeffsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgImageWidth: begin
          image_width_q <= cfg_data_i[DimW-1:0];
        end
        CfgImageHeight: begin
          image_height_q <= cfg_data_i[DimW-1:0];
        end
        CfgKernelCoeffs: begin
          kernel_coeffs_q <= cfg_data_i[KernW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  c3rb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .in_valid_i     (pix_in.valid),
    .in_pixel_i     (pix_in.pixel),
    .in_ready_o     (pix_in.ready),
    .job_valid_o    (job_valid),
    .job_o          (job),
    .job_ready_i    (job_ready)
  );

  c3rb_mac u_mac (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .kernel_coeffs_i (kernel_coeffs_q),
    .job_valid_i     (job_valid),
    .job_i           (job),
    .job_ready_o     (job_ready),
    .res_valid_o     (res_out.valid),
    .res_ready_i     (res_out.ready),
    .value_o         (res_out.value),
    .out_row_o       (res_out.out_row),
    .out_col_o       (res_out.out_col),
    .frame_end_o     (res_out.frame_end)
  );
endmodule
`default_nettype wire
